// ===== src/ppdm_pkg.sv =====
package ppdm_pkg;

	// Field and datapath widths
	localparam int STAMP_W = 32;
	localparam int LEN_W   = 48;
	localparam int SUM_W   = 50;
	localparam int NUM_W   = 55;
	localparam int PCT_W   = 7;
	localparam int OUT_W   = 104;
	localparam int STEP_W  = 3;

	// Constants
	localparam logic [LEN_W-1:0]   LEN_MAX    = 48'hFFFF_FFFF_FFFF;
	localparam logic [PCT_W-1:0]   PCT_SCALE  = 7'd100;
	localparam logic [STEP_W-1:0]  DIV_LAST   = 3'd6;
	localparam logic [STAMP_W-1:0] WRAP_RESET = 32'd999999;

	// Input kinds
	localparam logic KIND_EDGE = 1'b0;
	localparam logic KIND_WRAP = 1'b1;

	// Register indexes
	localparam logic CFG_WRAP_VALUE = 1'b0;
	localparam logic CFG_HIGH_SEL   = 1'b1;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic take;
		logic mul;
		logic sum;
		logic sub;
		logic high;
		logic prep;
		logic div;
		logic load;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic started;
		logic second_half;
		logic div_last;
	} sts_t;

endpackage

// ===== src/ppdm_dp.sv =====
module ppdm_dp
	import ppdm_pkg::*;
#(
	parameter int WRAP_COUNT_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [STAMP_W-1:0]   cfg_data,
	input  logic                 in_kind,
	input  logic [STAMP_W-1:0]   in_stamp,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	output logic [OUT_W-1:0]     out_data
);

	localparam int PROD_W = STAMP_W + WRAP_COUNT_BITS;

	logic [STAMP_W-1:0]         wrap_value_q;
	logic                       high_sel_q;
	logic                       started_q;
	logic                       second_half_q;
	logic [STAMP_W-1:0]         start_q;
	logic [WRAP_COUNT_BITS-1:0] wrap_q;
	logic [LEN_W-1:0]           first_seg_q;
	logic [STAMP_W-1:0]         stamp_q;
	logic [PROD_W-1:0]          prod_q;
	logic [SUM_W-1:0]           sum_q;
	logic                       ovf_q;
	logic [LEN_W-1:0]           period_q;
	logic [LEN_W-1:0]           high_q;
	logic [NUM_W-1:0]           rem_q;
	logic [NUM_W-1:0]           divisor_q;
	logic [PCT_W-1:0]           quot_q;
	logic [STEP_W-1:0]          step_q;
	logic                       zero_q;
	logic                       cap_q;
	logic [LEN_W-1:0]           out_period_q;
	logic [LEN_W-1:0]           out_high_q;
	logic [PCT_W-1:0]           out_pct_q;
	logic [SUM_W-1:0]           diff;
	logic [LEN_W-1:0]           seg;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_value_q <= WRAP_RESET;
			high_sel_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WRAP_VALUE: wrap_value_q <= cfg_data;
				CFG_HIGH_SEL:   high_sel_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Segment length from the registered sum, clamped at zero and at the maximum
	always_comb begin
		diff = sum_q - SUM_W'(start_q);
		if (ovf_q) begin
			seg = LEN_MAX;
		end else if (sum_q < SUM_W'(start_q)) begin
			seg = '0;
		end else if (diff > SUM_W'(LEN_MAX)) begin
			seg = LEN_MAX;
		end else begin
			seg = diff[LEN_W-1:0];
		end
	end

	// Measurement state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q     <= 1'b0;
			second_half_q <= 1'b0;
			start_q       <= '0;
			wrap_q        <= '0;
			first_seg_q   <= '0;
		end else begin
			if (cmd.take) begin
				if (in_kind == KIND_WRAP) begin
					if (started_q && (wrap_q != '1)) begin
						wrap_q <= wrap_q + 1'b1;
					end
				end else if (!started_q) begin
					started_q <= 1'b1;
					start_q   <= in_stamp;
				end
			end
			if (cmd.sub) begin
				if (!second_half_q) begin
					first_seg_q   <= seg;
					second_half_q <= 1'b1;
				end else begin
					start_q       <= stamp_q;
					wrap_q        <= '0;
					second_half_q <= 1'b0;
				end
			end
		end
	end

	// Arithmetic pipeline of one measurement
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			stamp_q <= in_stamp;
		end
		// Whole wrap intervals beyond the first
		if (cmd.mul) begin
			if (wrap_q == '0) begin
				prod_q <= '0;
			end else begin
				prod_q <= PROD_W'(wrap_value_q) * PROD_W'(wrap_q - 1'b1);
			end
		end
		// End point before the start stamp is taken off
		if (cmd.sum) begin
			ovf_q <= (wrap_q != '0) && (64'(prod_q) > 64'(LEN_MAX));
			if (wrap_q == '0) begin
				sum_q <= SUM_W'(stamp_q) + SUM_W'(1);
			end else begin
				sum_q <= SUM_W'(stamp_q) + SUM_W'(1) + SUM_W'(wrap_value_q)
					+ SUM_W'(prod_q);
			end
		end
		if (cmd.sub && second_half_q) begin
			period_q <= seg;
		end
		// High time from the first segment or the remainder
		if (cmd.high) begin
			if (!high_sel_q) begin
				high_q <= first_seg_q;
			end else if (period_q >= first_seg_q) begin
				high_q <= period_q - first_seg_q;
			end else begin
				high_q <= '0;
			end
		end
		// Division setup for the percentage
		if (cmd.prep) begin
			rem_q     <= NUM_W'(high_q) * NUM_W'(PCT_SCALE);
			divisor_q <= NUM_W'(period_q) << (PCT_W - 1);
			quot_q    <= '0;
			step_q    <= '0;
			zero_q    <= (period_q == '0);
			cap_q     <= (high_q >= period_q);
		end
		// One restoring division step a cycle
		if (cmd.div) begin
			if (rem_q >= divisor_q) begin
				rem_q  <= rem_q - divisor_q;
				quot_q <= {quot_q[PCT_W-2:0], 1'b1};
			end else begin
				quot_q <= {quot_q[PCT_W-2:0], 1'b0};
			end
			divisor_q <= divisor_q >> 1;
			step_q    <= step_q + 1'b1;
		end
		// Result register
		if (cmd.load) begin
			out_period_q <= period_q;
			out_high_q   <= high_q;
			if (zero_q) begin
				out_pct_q <= '0;
			end else if (cap_q) begin
				out_pct_q <= PCT_SCALE;
			end else begin
				out_pct_q <= quot_q;
			end
		end
	end

	assign sts.started     = started_q;
	assign sts.second_half = second_half_q;
	assign sts.div_last    = (step_q == DIV_LAST);

	assign out_data = {1'b0, out_pct_q, out_high_q, out_period_q};

	// Once started the meter never returns to the unstarted state
	a_started_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |=> started_q)
		else $error("started flag dropped");

	// The middle edge can only have been seen after the start edge
	a_half_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		second_half_q |-> started_q)
		else $error("second half without start");

endmodule

// ===== src/ppdm_ctrl.sv =====
module ppdm_ctrl
	import ppdm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	input  logic s_kind,
	output logic s_tready,
	output logic m_tvalid,
	input  logic m_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_SUM  = 3'd2;
	localparam logic [2:0] ST_SUB  = 3'd3;
	localparam logic [2:0] ST_HIGH = 3'd4;
	localparam logic [2:0] ST_PREP = 3'd5;
	localparam logic [2:0] ST_DIV  = 3'd6;
	localparam logic [2:0] ST_DONE = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       in_xact;
	logic       load_ok;

	assign s_tready = (state_q == ST_IDLE);
	assign in_xact  = s_tvalid && s_tready;
	assign load_ok  = (state_q == ST_DONE) && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;

	// Commands follow the state
	always_comb begin
		cmd      = '0;
		cmd.take = in_xact;
		cmd.mul  = (state_q == ST_MUL);
		cmd.sum  = (state_q == ST_SUM);
		cmd.sub  = (state_q == ST_SUB);
		cmd.high = (state_q == ST_HIGH);
		cmd.prep = (state_q == ST_PREP);
		cmd.div  = (state_q == ST_DIV);
		cmd.load = load_ok;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xact && (s_kind == KIND_EDGE) && sts.started) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL:  state_d = ST_SUM;
			ST_SUM:  state_d = ST_SUB;
			ST_SUB:  state_d = sts.second_half ? ST_HIGH : ST_IDLE;
			ST_HIGH: state_d = ST_PREP;
			ST_PREP: state_d = ST_DIV;
			ST_DIV: begin
				if (sts.div_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (load_ok) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State and result valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			priority if (load_ok) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end else begin
				out_valid_q <= out_valid_q;
			end
		end
	end

	// A finished result is always handed to the output register and the FSM frees up
	a_load_done: assert property (@(posedge clk) disable iff (!arst_n)
		load_ok |=> out_valid_q && (state_q == ST_IDLE))
		else $error("result not loaded");

	// At most one datapath step is commanded in a cycle
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("overlapping datapath commands");

	// An edge after the start always launches a segment computation
	a_edge_starts_seg: assert property (@(posedge clk) disable iff (!arst_n)
		in_xact && (s_kind == KIND_EDGE) && sts.started |=> state_q == ST_MUL)
		else $error("edge not processed");

endmodule

// ===== src/pulse_period_duty_meter.sv =====
// A wrap tick or the start edge only updates the state; the middle edge runs a multiply,
// a sum and a subtract step. The closing edge yields a result through one multiply,
// a sum and a subtract step, high time, setup and seven restoring division steps.
// Throughput: one item per cycle for ticks while idle; none while an edge is processed.
// A finished result waits in the output register while new items are accepted.
// arst_n clears the measurement state and restores the register defaults.
module pulse_period_duty_meter
	import ppdm_pkg::*;
#(
	parameter int WRAP_COUNT_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [STAMP_W-1:0] cfg_data,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [STAMP_W-1:0] s_tdata,   // stamp
	input  logic               s_tuser,   // kind
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [OUT_W-1:0]   m_tdata    // period_len, high_len, high_percent, zero pad
);

	cmd_t cmd;
	sts_t sts;

	// Sequencer
	ppdm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_kind   (s_tuser),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Arithmetic and measurement state
	ppdm_dp #(
		.WRAP_COUNT_BITS (WRAP_COUNT_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_kind   (s_tuser),
		.in_stamp  (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (m_tdata)
	);

endmodule

// ===== sim/ppdm_checker.sv =====
`timescale 1ns / 1ps

// Watches the register port and both stream channels of the meter, keeps its
// own copy of the measurement state and checks every reading in order.
module ppdm_checker
	import ppdm_pkg::*;
#(
	parameter int WRAP_COUNT_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [STAMP_W-1:0] cfg_data,
	input  logic               s_tvalid,
	input  logic               s_tready,
	input  logic [STAMP_W-1:0] s_tdata,   // stamp
	input  logic               s_tuser,   // kind
	input  logic               m_tvalid,
	input  logic               m_tready,
	input  logic [OUT_W-1:0]   m_tdata,   // period_len, high_len, high_percent, zero pad
	output int                 errors,
	output int                 pending,
	output int                 checked
);

	typedef struct {
		logic [LEN_W-1:0] period_len;
		logic [LEN_W-1:0] high_len;
		logic [PCT_W-1:0] high_percent;
	} reading_t;

	localparam logic [WRAP_COUNT_BITS-1:0] WRAPS_FULL = '1;

	// Register copies.
	logic [STAMP_W-1:0]         wrap_value;
	logic                       high_sel;

	// Measurement state.
	logic                       started;
	logic                       second_half;
	logic [STAMP_W-1:0]         start_stamp;
	logic [WRAP_COUNT_BITS-1:0] wraps;
	logic [LEN_W-1:0]           first_len;

	reading_t                   readings_due[$];
	int                         err_count;
	int                         readings_checked;

	// Timer counts from the start stamp to a stop stamp across the counted wraps.
	function automatic logic [LEN_W-1:0] elapsed_counts(input logic [STAMP_W-1:0] stop);
		logic [63:0] reload;
		logic [63:0] extra;
		logic [63:0] total;
		reload = 64'(wrap_value);
		if (wraps == '0) begin
			total = 64'(stop) + 64'd1;
		end else begin
			extra = reload * (64'(wraps) - 64'd1);
			if (extra > 64'(LEN_MAX))
				return LEN_MAX;
			total = reload + 64'(stop) + 64'd1 + extra;
		end
		if (total < 64'(start_stamp))
			return '0;
		total = total - 64'(start_stamp);
		if (total > 64'(LEN_MAX))
			return LEN_MAX;
		return total[LEN_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		reading_t         got;
		reading_t         want;
		logic [LEN_W-1:0] period;
		logic [LEN_W-1:0] high;
		logic [63:0]      pct;
		if (!arst_n) begin
			wrap_value = WRAP_RESET;
			high_sel = 1'b0;
			started = 1'b0;
			second_half = 1'b0;
			start_stamp = '0;
			wraps = '0;
			first_len = '0;
			readings_due.delete();
			err_count = 0;
			readings_checked = 0;
			errors <= 0;
			pending <= 0;
			checked <= 0;
		end else begin
			// Compare a result transaction with the oldest predicted reading.
			if (m_tvalid && m_tready) begin
				got.period_len = m_tdata[LEN_W-1:0];
				got.high_len = m_tdata[2*LEN_W-1:LEN_W];
				got.high_percent = m_tdata[2*LEN_W+PCT_W-1:2*LEN_W];
				if (readings_due.size() == 0) begin
					$display("%0t: unexpected reading, expected none, got period %0d high %0d pct %0d",
						$time, got.period_len, got.high_len, got.high_percent);
					err_count++;
				end else begin
					want = readings_due.pop_front();
					readings_checked++;
					if (got.period_len !== want.period_len) begin
						$display("%0t: period_len expected %0d, got %0d",
							$time, want.period_len, got.period_len);
						err_count++;
					end
					if (got.high_len !== want.high_len) begin
						$display("%0t: high_len expected %0d, got %0d",
							$time, want.high_len, got.high_len);
						err_count++;
					end
					if (got.high_percent !== want.high_percent) begin
						$display("%0t: high_percent expected %0d, got %0d",
							$time, want.high_percent, got.high_percent);
						err_count++;
					end
				end
			end

			// Track register writes.
			if (cfg_we) begin
				if (cfg_index == CFG_WRAP_VALUE)
					wrap_value = cfg_data;
				else if (cfg_index == CFG_HIGH_SEL)
					high_sel = cfg_data[0];
			end

			// Advance the measurement on each input transaction.
			if (s_tvalid && s_tready) begin
				if (s_tuser == KIND_WRAP) begin
					if (started && wraps != WRAPS_FULL)
						wraps = wraps + 1'b1;
				end else if (!started) begin
					started = 1'b1;
					start_stamp = s_tdata;
				end else if (!second_half) begin
					first_len = elapsed_counts(s_tdata);
					second_half = 1'b1;
				end else begin
					period = elapsed_counts(s_tdata);
					if (high_sel)
						high = (period >= first_len) ? period - first_len : '0;
					else
						high = first_len;
					if (period == '0) begin
						pct = '0;
					end else begin
						pct = (64'(high) * 64'(PCT_SCALE)) / 64'(period);
						if (pct > 64'(PCT_SCALE))
							pct = 64'(PCT_SCALE);
					end
					want.period_len = period;
					want.high_len = high;
					want.high_percent = pct[PCT_W-1:0];
					readings_due.push_back(want);
					start_stamp = s_tdata;
					wraps = '0;
					second_half = 1'b0;
				end
			end

			errors <= err_count;
			pending <= readings_due.size();
			checked <= readings_checked;
		end
	end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb
	import ppdm_pkg::*;
();

	localparam int WRAP_COUNT_BITS = 16;
	localparam int CYCLE_LIMIT     = 1_000_000;
	localparam int RESET_CYCLES    = 12;
	localparam int SETTLE_CYCLES   = 30;
	localparam int HOLD_CYCLES     = 400;
	localparam int BURST_TICKS     = 40;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 125;

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               cfg_we    = 1'b0;
	logic               cfg_index = CFG_WRAP_VALUE;
	logic [STAMP_W-1:0] cfg_data  = '0;
	logic               s_tvalid  = 1'b0;
	logic               s_tready;
	logic [STAMP_W-1:0] s_tdata   = '0;   // stamp
	logic               s_tuser   = KIND_EDGE;   // kind
	logic               m_tvalid;
	logic               m_tready  = 1'b0;
	logic [OUT_W-1:0]   m_tdata;   // period_len, high_len, high_percent, zero pad

	int                 errors;
	int                 pending;
	int                 checked;

	int                 send_idle_pct  = 0;
	int                 recv_stall_pct = 0;
	int                 hold_request   = 0;
	int                 items_sent     = 0;
	int                 settings_used  = 0;
	longint             cycles         = 0;
	longint unsigned    tpos           = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	pulse_period_duty_meter #(
		.WRAP_COUNT_BITS(WRAP_COUNT_BITS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	ppdm_checker #(
		.WRAP_COUNT_BITS(WRAP_COUNT_BITS)
	) u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.errors   (errors),
		.pending  (pending),
		.checked  (checked)
	);

	// Result side: random stalls, or a long hold-off when one is requested.
	always @(posedge clk) begin : result_sink
		int hold_left;
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Offer one input transaction, idling first as the sender pattern says.
	task automatic send_item(input logic kind, input logic [STAMP_W-1:0] stamp);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= stamp;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_edge(input logic [STAMP_W-1:0] stamp);
		send_item(KIND_EDGE, stamp);
	endtask

	task automatic send_wrap();
		send_item(KIND_WRAP, $urandom);
	endtask

	// Stop offering and wait until every predicted reading has come out.
	task automatic drain(input int settle);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// Write both registers on consecutive cycles; only called while idle.
	task automatic configure(input logic [STAMP_W-1:0] wrap_val, input logic high_second);
		cfg_we <= 1'b1;
		cfg_index <= CFG_WRAP_VALUE;
		cfg_data <= wrap_val;
		@(posedge clk);
		cfg_index <= CFG_HIGH_SEL;
		cfg_data <= {{(STAMP_W-1){1'b0}}, high_second};
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	// A realistic edge: the timer runs on by a random amount, wrapping as it goes.
	task automatic timeline_edge(input logic [STAMP_W-1:0] wrap_val);
		longint unsigned span;
		longint unsigned delta;
		longint unsigned pos;
		int              n_wraps;
		span = 64'(wrap_val) + 64'd1;
		if ($urandom_range(9, 0) == 0)
			delta = span * $urandom_range(20, 3) + ({$urandom, $urandom} % span);
		else
			delta = ({$urandom, $urandom} % (2 * span)) + 64'd1;
		pos = tpos + delta;
		n_wraps = int'(pos / span);
		tpos = pos % span;
		repeat (n_wraps) send_wrap();
		send_edge(tpos[STAMP_W-1:0]);
	endtask

	// Noise: a few stray ticks and an edge with an arbitrary stamp.
	task automatic noise_edge(input logic [STAMP_W-1:0] wrap_val);
		logic [STAMP_W-1:0] stamp;
		stamp = $urandom;
		repeat ($urandom_range(4, 0)) send_wrap();
		send_edge(stamp);
		tpos = 64'(stamp) % (64'(wrap_val) + 64'd1);
	endtask

	initial begin : stimulus
		logic [STAMP_W-1:0] wrap_val;
		logic               high_second;
		int                 phase_base;
		bit                 paused;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at reset defaults: ticks before any start are ignored.
		send_wrap();
		send_wrap();
		// Stamp above the wrap value, high time longer than the period.
		send_edge('0);
		send_edge('1);
		send_edge(WRAP_RESET);
		// One wrap in the first segment, four by the end of the period.
		send_wrap();
		send_edge('0);
		repeat (3) send_wrap();
		send_edge(WRAP_RESET);
		// Stamp before start gives an empty segment, then an empty period.
		send_edge(32'd5);
		send_edge(WRAP_RESET - 32'd1);
		drain(SETTLE_CYCLES);

		// High time as the remainder, including a remainder below zero.
		configure(WRAP_RESET, 1'b1);
		send_edge('1);
		send_edge('0);
		send_edge(32'd700);
		send_edge(32'd300);
		send_edge(32'd400);
		send_edge(32'd1300);
		drain(SETTLE_CYCLES);

		// A long burst of ticks at full scale wrap value.
		configure('1, 1'b0);
		repeat (BURST_TICKS) send_wrap();
		send_edge('0);
		send_edge('1);
		drain(SETTLE_CYCLES);

		// Random phases over register settings and idle patterns.
		paused = 1'b0;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0:       wrap_val = WRAP_RESET;
				1:       wrap_val = 32'd1;
				2:       wrap_val = '1;
				3:       wrap_val = '0;
				4:       wrap_val = $urandom_range(1000, 2);
				5:       wrap_val = $urandom;
				6:       wrap_val = $urandom_range(100000, 1000);
				default: wrap_val = '1;
			endcase
			high_second = (p == 6) ? 1'($urandom_range(1, 0)) : 1'(p % 2);
			case (idle_mode_t'(p % 4))
				IDLE_NONE: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				IDLE_SEND: begin
					send_idle_pct = 82;
					recv_stall_pct = 0;
				end
				IDLE_RECV: begin
					send_idle_pct = 0;
					recv_stall_pct = 82;
				end
				default: begin
					send_idle_pct = 18;
					recv_stall_pct = 18;
				end
			endcase
			drain(SETTLE_CYCLES);
			configure(wrap_val, high_second);
			tpos = 64'($urandom) % (64'(wrap_val) + 64'd1);
			// Long receiver hold-off while the sender keeps offering.
			if (p == 0)
				hold_request = HOLD_CYCLES;
			phase_base = items_sent;
			while (items_sent - phase_base < ITEMS_PER_PHASE) begin
				if ($urandom_range(99, 0) < 85)
					timeline_edge(wrap_val);
				else
					noise_edge(wrap_val);
				// Sender pauses mid-phase until all readings are out.
				if (p == 4 && !paused && items_sent - phase_base >= ITEMS_PER_PHASE / 2) begin
					drain(0);
					paused = 1'b1;
				end
			end
		end

		recv_stall_pct = 0;
		drain(SETTLE_CYCLES);

		$display("tb: %0d input transactions offered, %0d readings checked", items_sent, checked);
		$display("tb: %0d register settings incl. zero and full scale wrap values,",
			settings_used);
		$display("tb: every idle pattern, a long result hold-off and a full drain");
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== files.f =====
src/ppdm_pkg.sv
src/ppdm_dp.sv
src/ppdm_ctrl.sv
src/pulse_period_duty_meter.sv
sim/ppdm_checker.sv
sim/tb.sv
